>>> sv/hsfc_pkg.sv
// Shared types, constants and functions of the humidity sensor frame checker.
package hsfc_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_TEMP_CRC = 2'd2,
        ST_HUM_CRC  = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
        status_t     status;
    } frame_t;

    // One byte of CRC-8, MSB first, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Exact floor(n / 65535) for quotients below 65536: (n + (n >> 16) + 1) >> 16.
    function automatic logic [15:0] div_65535(input logic [30:0] n);
        logic [31:0] sum;
        sum = 32'(n) + 32'(n[30:16]) + 32'd1;
        return sum[31:16];
    endfunction

endpackage

>>> sv/hsfc_front.sv
// Front end: tracks the byte position, runs the CRC and builds the frame record.
module hsfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sensor_enabled,
    input  logic            byte_accept,
    input  logic [7:0]      byte_value,
    input  logic            frame_start,
    output logic            push,
    output hsfc_pkg::frame_t frame
);
    import hsfc_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] tword_reg, tword_next;
    logic        tgood_reg, tgood_next;
    logic [15:0] hword_reg, hword_next;
    logic [2:0]  pos;

    always_comb begin
        pos = (frame_start || pos_reg > 3'd5) ? 3'd0 : pos_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        tword_next = tword_reg;
        tgood_next = tgood_reg;
        hword_next = hword_reg;
        push       = 1'b0;

        frame.raw_temperature = tword_reg;
        frame.raw_humidity    = hword_reg;
        if (!sensor_enabled)
            frame.status = ST_DISABLED;
        else if (!tgood_reg)
            frame.status = ST_TEMP_CRC;
        else if (crc_reg != byte_value)
            frame.status = ST_HUM_CRC;
        else
            frame.status = ST_OK;

        if (byte_accept) begin
            pos_next = pos + 3'd1;
            case (pos)
                3'd0:
                begin
                    crc_next   = crc8_byte(CRC_INIT, byte_value);
                    tword_next = {byte_value, 8'h00};
                end
                3'd1:
                begin
                    crc_next   = crc8_byte(crc_reg, byte_value);
                    tword_next = {tword_reg[15:8], byte_value};
                end
                3'd2:
                begin
                    tgood_next = (crc_reg == byte_value);
                    crc_next   = CRC_INIT;
                end
                3'd3:
                begin
                    crc_next   = crc8_byte(CRC_INIT, byte_value);
                    hword_next = {byte_value, 8'h00};
                end
                3'd4:
                begin
                    crc_next   = crc8_byte(crc_reg, byte_value);
                    hword_next = {hword_reg[15:8], byte_value};
                end
                default:
                begin
                    crc_next = CRC_INIT;
                    pos_next = 3'd0;
                    push     = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg   <= 3'd0;
            crc_reg   <= CRC_INIT;
            tword_reg <= 16'd0;
            tgood_reg <= 1'b0;
            hword_reg <= 16'd0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            tword_reg <= tword_next;
            tgood_reg <= tgood_next;
            hword_reg <= hword_next;
        end
    end

endmodule

>>> sv/hsfc_queue.sv
// Two-entry queue of finished frame records between front and back end.
module hsfc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hsfc_pkg::frame_t push_frame,
    input  logic             pop,
    output hsfc_pkg::frame_t pop_frame,
    output logic             full,
    output logic             empty
);
    import hsfc_pkg::*;

    frame_t     mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign empty     = (count_reg == 2'd0);
    assign pop_frame = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/hsfc_back.sv
// Back end: scales the raw words in two stages and holds the result beat.
module hsfc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  hsfc_pkg::frame_t in_frame,
    output logic             in_take,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [14:0]      temperature_centi,
    output logic [13:0]      humidity_centi,
    output hsfc_pkg::frame_t out_frame
);
    import hsfc_pkg::*;

    // Stage one: products.
    logic        s1_valid_reg, s1_valid_next;
    frame_t      s1_frame_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    // Stage two: result beat.
    logic        out_valid_reg, out_valid_next;
    frame_t      out_frame_reg;
    logic [14:0] temp_reg, temp_next;
    logic [13:0] hum_reg, hum_next;

    logic        adv2, adv1;
    logic [15:0] tq, hq;

    assign adv2    = !out_valid_reg || out_ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign in_take = in_valid && adv1;

    always_comb begin
        s1_valid_next  = adv1 ? in_valid : s1_valid_reg;
        out_valid_next = adv2 ? s1_valid_reg : out_valid_reg;
        tq = div_65535(s1_tprod_reg);
        hq = div_65535({1'b0, s1_hprod_reg});
        if (s1_frame_reg.status == ST_OK) begin
            temp_next = tq[14:0] - TEMP_OFFSET;
            hum_next  = hq[13:0];
        end else begin
            temp_next = 15'd0;
            hum_next  = 14'd0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_take) begin
            s1_frame_reg <= in_frame;
            s1_tprod_reg <= 31'(in_frame.raw_temperature) * 31'(TEMP_SPAN);
            s1_hprod_reg <= 30'(in_frame.raw_humidity) * 30'(HUM_SPAN);
        end
        if (adv2 && s1_valid_reg) begin
            out_frame_reg <= s1_frame_reg;
            temp_reg      <= temp_next;
            hum_reg       <= hum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_frame         = out_frame_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;

endmodule

>>> sv/humidity_sensor_frame_checker.sv
// Top level of the humidity sensor frame checker: ports, wiring and assertions.
//
// The block takes the six response bytes of a humidity/temperature sensor,
// one byte per beat on the slave stream: temperature word (high byte first),
// its CRC, humidity word (high byte first), and its CRC. Each word is checked
// with CRC-8 (polynomial 0x31, initial value 0xFF, MSB first). A beat with
// s_tuser set starts a new frame and drops any partial one; after a finished
// frame the next byte starts a new frame in any case. After the sixth byte the
// block emits one result beat holding both raw words, temperature in
// hundredths of a degree Celsius (-4500 + floor(17500*raw/65535)), humidity
// in hundredths of a percent (floor(10000*raw/65535)) and a status: 0 ok,
// 1 not enabled, 2 temperature CRC error, 3 humidity CRC error, checked in
// that order of precedence after "not enabled". On any non-ok status both
// scaled values read zero. The block accepts one byte every clock cycle while
// the queue is not full. The sixth byte's record enters the queue, then the
// multiplier product registers, then the result beat with the divide by 65535
// and offset. A two-entry queue between the byte-level front end and the
// scaling back end lets either side stall; s_tready drops only while that
// queue is full. The enable register is written over the cfg channel, which
// is always ready, and should only be changed while no frame is in flight.
module humidity_sensor_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi, [44:29] raw_temperature,
    // [60:45] raw_humidity, [62:61] status, [63] zero
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // [0] sensor_enabled
);
    import hsfc_pkg::*;

    logic        enabled_reg, enabled_next;
    logic        byte_accept;
    logic        push;
    frame_t      push_frame;
    frame_t      pop_frame;
    logic        q_full, q_empty, q_pop;
    frame_t      out_frame;
    logic [14:0] temperature_centi;
    logic [13:0] humidity_centi;

    // Configuration register: written whenever the channel hands over a beat.
    assign cfg_ready    = 1'b1;
    assign enabled_next = (cfg_valid && cfg_ready) ? cfg_data : enabled_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else
            enabled_reg <= enabled_next;
    end

    // A byte is refused only while the queue has no room for a finished frame.
    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    hsfc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sensor_enabled (enabled_reg),
        .byte_accept    (byte_accept),
        .byte_value     (s_tdata),
        .frame_start    (s_tuser),
        .push           (push),
        .frame          (push_frame)
    );

    hsfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (q_pop),
        .pop_frame  (pop_frame),
        .full       (q_full),
        .empty      (q_empty)
    );

    hsfc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (!q_empty),
        .in_frame          (pop_frame),
        .in_take           (q_pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .out_frame         (out_frame)
    );

    assign m_tdata = {1'b0, out_frame.status, out_frame.raw_humidity,
                      out_frame.raw_temperature, humidity_centi, temperature_centi};

    // A frame record is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("frame record pushed into a full queue");

    // A non-ok status carries zero scaled values.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_frame.status != ST_OK) |->
            (temperature_centi == 15'd0 && humidity_centi == 14'd0))
        else $error("scaled values not zero on an error status");

    // Scaled humidity of a good frame never exceeds 100.00 percent.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_frame.status == ST_OK) |-> (humidity_centi <= HUM_SPAN))
        else $error("humidity out of range");

    // The queue is only popped when it holds an entry.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the humidity sensor frame checker.
module testbench;

    import hsfc_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  SETTLE_BEATS = 16;
    localparam int  TEMP_SCALE   = 17500;
    localparam int  TEMP_BIAS    = 4500;
    localparam int  HUM_SCALE    = 10000;
    localparam int  WORD_FULL    = 65535;

    typedef struct {
        logic [7:0] value;
        logic       start;
    } rx_byte_t;

    typedef struct {
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
        status_t            status;
    } reading_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    rx_byte_t pending_bytes[$];
    reading_t expected_readings[$];

    // Idle and stall rates in percent, changed between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count    = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned readings_seen  = 0;
    int unsigned enable_writes  = 0;
    int unsigned mismatches     = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    // Shadow of the frame checker: register, byte position, CRC and words.
    logic        enable_shadow   = 1'b0;
    logic [2:0]  frame_pos       = 3'd0;
    logic [7:0]  crc_acc         = CRC_INIT;
    logic [15:0] temp_word       = 16'h0000;
    logic        temp_crc_ok     = 1'b0;
    logic [15:0] hum_word        = 16'h0000;

    humidity_sensor_frame_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // CRC-8 fed one data bit at a time, MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advances the shadow by one accepted byte and queues a reading after
    // the sixth byte of a frame.
    task automatic absorb_byte(input logic [7:0] b, input logic start);
        reading_t   r;
        logic       hum_ok;
        logic [2:0] pos;
        pos = (start || frame_pos > 3'd5) ? 3'd0 : frame_pos;
        case (pos)
            3'd0:
            begin
                crc_acc   = crc8_next(CRC_INIT, b);
                temp_word = {b, 8'h00};
            end
            3'd1:
            begin
                crc_acc        = crc8_next(crc_acc, b);
                temp_word[7:0] = b;
            end
            3'd2:
            begin
                temp_crc_ok = (crc_acc == b);
                crc_acc     = CRC_INIT;
            end
            3'd3:
            begin
                crc_acc  = crc8_next(CRC_INIT, b);
                hum_word = {b, 8'h00};
            end
            3'd4:
            begin
                crc_acc       = crc8_next(crc_acc, b);
                hum_word[7:0] = b;
            end
            default:
            begin
                hum_ok  = (crc_acc == b);
                crc_acc = CRC_INIT;
                if (!enable_shadow)
                    r.status = ST_DISABLED;
                else if (!temp_crc_ok)
                    r.status = ST_TEMP_CRC;
                else if (!hum_ok)
                    r.status = ST_HUM_CRC;
                else
                    r.status = ST_OK;
                r.temp_raw   = temp_word;
                r.hum_raw    = hum_word;
                r.temp_centi = '0;
                r.hum_centi  = '0;
                if (r.status == ST_OK)
                begin
                    r.temp_centi = 15'(longint'(temp_word) * TEMP_SCALE / WORD_FULL - TEMP_BIAS);
                    r.hum_centi  = 14'(longint'(hum_word) * HUM_SCALE / WORD_FULL);
                end
                expected_readings.push_back(r);
            end
        endcase
        frame_pos = (pos == 3'd5) ? 3'd0 : pos + 3'd1;
    endtask

    // Slave-side driver: presents queued bytes, holding each until accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata, s_tuser);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rx_byte_t nb;
                    nb = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.value;
                    s_tuser  <= nb.start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Master-side monitor: every result beat is matched against the oldest
    // expected reading.
    always @(posedge clk)
    begin : result_monitor
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                $error("result beat with no reading expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_readings.pop_front();
                status_seen[want.status]++;
                check_field("temperature_centi", longint'(want.temp_centi),
                            longint'($signed(m_tdata[14:0])));
                check_field("humidity_centi", longint'(want.hum_centi), longint'(m_tdata[28:15]));
                check_field("raw_temperature", longint'(want.temp_raw), longint'(m_tdata[44:29]));
                check_field("raw_humidity", longint'(want.hum_raw), longint'(m_tdata[60:45]));
                check_field("status", longint'(want.status), longint'(m_tdata[62:61]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic start);
        rx_byte_t nb;
        nb.value = value;
        nb.start = start;
        pending_bytes.push_back(nb);
        bytes_queued++;
    endtask

    // Queues one six-byte frame; a bad CRC is the good one with some bits flipped.
    task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic start, input logic t_bad, input logic h_bad);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = crc8_next(crc8_next(CRC_INIT, t_raw[15:8]), t_raw[7:0]);
        h_crc = crc8_next(crc8_next(CRC_INIT, h_raw[15:8]), h_raw[7:0]);
        if (t_bad)
            t_crc ^= 8'($urandom_range(1, 255));
        if (h_bad)
            h_crc ^= 8'($urandom_range(1, 255));
        push_byte(t_raw[15:8], start);
        push_byte(t_raw[7:0], 1'b0);
        push_byte(t_crc, 1'b0);
        push_byte(h_raw[15:8], 1'b0);
        push_byte(h_raw[7:0], 1'b0);
        push_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] edges[4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
        if ($urandom_range(7) == 0)
            return edges[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    // Waits until every byte is taken and every reading has come back, then
    // lets the back end settle so that nothing is in flight.
    task automatic drain();
        while (pending_bytes.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_BEATS) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        enable_shadow = value;
        enable_writes++;
        cfg_valid <= 1'b0;
    endtask

    // One random phase: mostly well-formed frames with random words and some
    // corrupted CRCs, mixed with short runs of stray bytes that leave the
    // frame position anywhere. Each phase ends on a whole frame.
    task automatic random_phase(input logic enable, input int unsigned idle_pct,
                                input int unsigned stall_pct, input int unsigned n_bytes);
        int unsigned first;
        int unsigned k;
        logic        aligned;
        write_enable(enable);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first   = bytes_queued;
        aligned = 1'b1;
        while (bytes_queued - first < n_bytes)
        begin
            if ($urandom_range(99) < 12)
            begin
                k = $urandom_range(1, 5);
                repeat (k) push_byte(8'($urandom), 1'($urandom_range(1)));
                aligned = 1'b0;
            end
            else
            begin
                k = $urandom_range(9);
                push_frame(pick_word(), pick_word(), aligned ? 1'($urandom_range(1)) : 1'b1,
                           k < 2, k == 2 || k == 3 || k == 9);
                aligned = 1'b1;
            end
        end
        if (!aligned)
            push_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Still disabled from reset: not enabled must win over both CRC errors.
        push_frame(16'hBEEF, 16'h1234, 1'b1, 1'b1, 1'b1);
        drain();
        write_enable(1'b1);

        // Extremes of both conversions, the second frame carrying no start mark.
        push_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        // Both CRCs bad: the temperature error takes precedence.
        push_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1);
        // A partial frame dropped by a restart, then a humidity CRC error.
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1);
        drain();

        random_phase(1'b1, 0, 0, 400);
        random_phase(1'b1, 72, 0, 300);
        random_phase(1'b0, 0, 72, 200);
        random_phase(1'b1, 6, 6, 500);

        $display("summary: %0d bytes accepted, %0d readings, %0d enable writes",
                 bytes_accepted, readings_seen, enable_writes);
        $display("summary: status ok %0d, disabled %0d, temperature crc %0d, humidity crc %0d",
                 status_seen[ST_OK], status_seen[ST_DISABLED],
                 status_seen[ST_TEMP_CRC], status_seen[ST_HUM_CRC]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
sv/hsfc_pkg.sv
sv/hsfc_front.sv
sv/hsfc_queue.sv
sv/hsfc_back.sv
sv/humidity_sensor_frame_checker.sv
dv/testbench.sv
